### rtl/core/csfp_pkg.sv
// Shared constants and codes for the checksum frame parser.
`timescale 1ns / 1ps

package csfp_pkg;

  // Largest frame in bytes, start and stop codes included
  localparam int unsigned MAX_FRAME_BYTES = 128;

  // Payload length bounds
  localparam logic [7:0] LEN_MIN = 8'd3;
  localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME_BYTES - 5);

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned FLEN_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Stream payload widths: tdata = {frame_length, byte_position}, padded
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = STATUS_W + 1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_BUSY  = 2'd0,
    ST_ERROR = 2'd1,
    ST_DONE  = 2'd2
  } status_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTL_CODE_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTL_CODE_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CTL_CODE_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTL_CODE_D = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTL_CODE_E = 3'd6;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd104;
  localparam logic [BYTE_W-1:0] STOP_CODE_RST  = 8'd22;
  localparam logic [BYTE_W-1:0] CTL_CODE_A_RST = 8'd1;
  localparam logic [BYTE_W-1:0] CTL_CODE_B_RST = 8'd2;
  localparam logic [BYTE_W-1:0] CTL_CODE_C_RST = 8'd3;
  localparam logic [BYTE_W-1:0] CTL_CODE_D_RST = 8'd4;
  localparam logic [BYTE_W-1:0] CTL_CODE_E_RST = 8'd5;

endpackage

### rtl/core/checksum_frame_parser.sv
// Top level of the start/stop delimited frame parser with additive checksum.
`timescale 1ns / 1ps

// Byte-serial frame parser. Each received byte on the slave stream is checked
// against the layout start code, control code, length L (3 to
// MAX_FRAME_BYTES-5), L payload bytes, 8-bit wrapping checksum of control,
// length and payload, stop code. Every byte yields exactly one result
// transaction on the master stream: status busy, error (parser back to idle,
// the byte is not retried as a start) or done (frame_length = L + 5), with
// byte_kept and the byte's offset in the frame. Rate: one byte per clock
// cycle while the master stream is ready; the parse state update and the
// result are computed combinationally into one output register, which is
// refilled in the same cycle it is taken. The result is valid in the cycle
// after the byte is accepted. Configuration writes are always ready and
// should only be issued while no results are pending.
module checksum_frame_parser (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Slave stream: tdata = rx_byte[7:0]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [csfp_pkg::BYTE_W-1:0]          s_axis_tdata,
  // Master stream: tdata = byte_position[6:0], frame_length[14:7], zero[15]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [csfp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // Master stream: tuser = status[1:0], byte_kept[2]
  output logic [csfp_pkg::OUT_USER_W-1:0]      m_axis_tuser,
  // Configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [csfp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [csfp_pkg::BYTE_W-1:0]          cfg_data_i
);
  import csfp_pkg::*;

  // Parse phases
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_CTL   = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_SUM   = 3'd4;
  localparam logic [2:0] PH_STOP  = 3'd5;

  // Configuration registers
  logic [BYTE_W-1:0] start_code_q, stop_code_q;
  logic [BYTE_W-1:0] ctl_a_q, ctl_b_q, ctl_c_q, ctl_d_q, ctl_e_q;

  // Parse state
  logic [2:0]        phase_q, phase_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] left_q, left_d;
  logic [BYTE_W-1:0] count_q, count_d;

  // Result register
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic              kept_q, kept_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [FLEN_W-1:0] flen_q, flen_d;

  logic in_fire;
  logic cfg_fire;
  logic ctl_match;
  logic [BYTE_W-1:0] pos_full;
  logic [BYTE_W-1:0] pos_next;
  logic [BYTE_W-1:0] left_dec;
  logic              ok;
  logic              done;

  // Handshakes: output register frees up when empty or being taken
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= START_CODE_RST;
      stop_code_q  <= STOP_CODE_RST;
      ctl_a_q      <= CTL_CODE_A_RST;
      ctl_b_q      <= CTL_CODE_B_RST;
      ctl_c_q      <= CTL_CODE_C_RST;
      ctl_d_q      <= CTL_CODE_D_RST;
      ctl_e_q      <= CTL_CODE_E_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_START_CODE: start_code_q <= cfg_data_i;
        REG_STOP_CODE:  stop_code_q  <= cfg_data_i;
        REG_CTL_CODE_A: ctl_a_q      <= cfg_data_i;
        REG_CTL_CODE_B: ctl_b_q      <= cfg_data_i;
        REG_CTL_CODE_C: ctl_c_q      <= cfg_data_i;
        REG_CTL_CODE_D: ctl_d_q      <= cfg_data_i;
        REG_CTL_CODE_E: ctl_e_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control code check against the five configured codes
  assign ctl_match = (s_axis_tdata == ctl_a_q) || (s_axis_tdata == ctl_b_q) ||
                     (s_axis_tdata == ctl_c_q) || (s_axis_tdata == ctl_d_q) ||
                     (s_axis_tdata == ctl_e_q);

  assign left_dec = (left_q != '0) ? left_q - 8'd1 : left_q;

  // Next parse state and result for the byte on the input
  always_comb begin
    phase_d  = phase_q;
    sum_d    = sum_q;
    left_d   = left_q;
    count_d  = count_q;
    ok       = 1'b0;
    done     = 1'b0;
    pos_full = count_q;

    unique case (phase_q)
      PH_START: begin
        if (s_axis_tdata == start_code_q) begin
          sum_d    = '0;
          left_d   = '0;
          pos_full = '0;
          phase_d  = PH_CTL;
          ok       = 1'b1;
        end
      end
      PH_CTL: begin
        if (ctl_match) begin
          sum_d   = s_axis_tdata;
          phase_d = PH_LEN;
          ok      = 1'b1;
        end
      end
      PH_LEN: begin
        if (s_axis_tdata >= LEN_MIN && s_axis_tdata <= LEN_MAX) begin
          left_d  = s_axis_tdata;
          sum_d   = sum_q + s_axis_tdata;
          phase_d = PH_DATA;
          ok      = 1'b1;
        end
      end
      PH_DATA: begin
        left_d = left_dec;
        sum_d  = sum_q + s_axis_tdata;
        if (left_dec == '0) begin
          phase_d = PH_SUM;
        end
        ok = 1'b1;
      end
      PH_SUM: begin
        if (s_axis_tdata == sum_q) begin
          phase_d = PH_STOP;
          ok      = 1'b1;
        end
      end
      PH_STOP: begin
        if (s_axis_tdata == stop_code_q) begin
          done = 1'b1;
          ok   = 1'b1;
        end
      end
      default: ;
    endcase

    pos_next = pos_full + 8'd1;

    // Error or frame end both return to idle
    if (!ok || done) begin
      phase_d = PH_START;
      sum_d   = '0;
      left_d  = '0;
      count_d = '0;
    end else begin
      count_d = pos_next;
    end

    // Result fields
    if (!ok) begin
      status_d = ST_ERROR;
      kept_d   = 1'b0;
      pos_d    = '0;
      flen_d   = '0;
    end else begin
      status_d = done ? ST_DONE : ST_BUSY;
      kept_d   = 1'b1;
      pos_d    = pos_full[POS_W-1:0];
      flen_d   = done ? pos_next : '0;
    end
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      sum_q   <= '0;
      left_q  <= '0;
      count_q <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      left_q  <= left_d;
      count_q <= count_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      kept_q   <= kept_d;
      pos_q    <= pos_d;
      flen_q   <= flen_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, flen_q, pos_q};
  assign m_axis_tuser  = {kept_q, status_q};

endmodule

### rtl/core/csfp_checker.sv
// Port-level assertions for the checksum frame parser, bound to the top level.
`timescale 1ns / 1ps

module csfp_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [csfp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input logic [csfp_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
  import csfp_pkg::*;

  logic [STATUS_W-1:0] status;
  logic                kept;
  logic [POS_W-1:0]    pos;
  logic [FLEN_W-1:0]   flen;

  assign status = m_axis_tuser[STATUS_W-1:0];
  assign kept   = m_axis_tuser[STATUS_W];
  assign pos    = m_axis_tdata[POS_W-1:0];
  assign flen   = m_axis_tdata[POS_W+FLEN_W-1:POS_W];

  // An error result carries no kept byte, position or length
  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == ST_ERROR) |-> (!kept && pos == '0 && flen == '0))
    else $error("error result with non-zero fields");

  // Frame length appears only on a completed frame, and then covers the stop byte
  a_flen_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((status == ST_DONE) ? (flen == {1'b0, pos} + 8'd1) : (flen == '0)))
    else $error("frame length inconsistent with status");

  // Every accepted byte produces a result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted byte did not produce a result");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind checksum_frame_parser csfp_checker u_csfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
